// ===== rtl/segment_aabb_overlap_test_macros.svh =====
// assertion macros for the segment/box overlap block
// used by the port checker; expects clk_i and rst_ni in scope
`ifndef SEGMENT_AABB_OVERLAP_TEST_MACROS_SVH
`define SEGMENT_AABB_OVERLAP_TEST_MACROS_SVH

// checked only while out of reset
`define SAO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sao assertion failed");

// checked at every edge, reset included
`define SAO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sao assertion failed");

`endif

// ===== rtl/sao_pkg.sv =====
// shared widths, value types and stage enable struct for the overlap block
// no dependencies
package sao_pkg;

  localparam int COORD_BITS = 24;
  localparam int TW = COORD_BITS + 3;  // doubled center offset
  localparam int EW = COORD_BITS + 1;  // doubled extent
  localparam int DW = COORD_BITS + 1;  // direction
  localparam int MW = COORD_BITS + 1;  // direction magnitude, unsigned
  localparam int FW = TW + 1;          // face test compare
  localparam int PW = TW + DW;         // products
  localparam int SW = PW + 1;          // product sums

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TW-1:0]         tval_t;
  typedef logic signed [EW-1:0]         eval_t;
  typedef logic signed [DW-1:0]         dval_t;
  typedef logic        [MW-1:0]         dmag_t;
  typedef logic signed [FW-1:0]         fval_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SW-1:0]         sum_t;
  typedef logic signed [SW:0]           cmp_t;

  // register enables for the stages held outside the top level
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } sao_en_t;

endpackage

// ===== rtl/sao_prep.sv =====
// stages 1 and 2: offset/extent/direction, face axis tests, direction magnitudes
// depends on sao_pkg
module sao_prep (
  input  logic            clk_i,
  input  sao_pkg::sao_en_t en_i,
  input  sao_pkg::coord_t p1_i   [3],
  input  sao_pkg::coord_t p2_i   [3],
  input  sao_pkg::coord_t lo_i   [3],
  input  sao_pkg::coord_t hi_i   [3],
  output sao_pkg::tval_t  t_o    [3],
  output sao_pkg::eval_t  e_o    [3],
  output sao_pkg::dval_t  d_o    [3],
  output sao_pkg::dmag_t  dmag_o [3],
  output logic            face_ok_o
);
  import sao_pkg::*;

  tval_t t_q  [3];
  eval_t e_q  [3];
  dval_t d_q  [3];
  tval_t t2_q [3];
  eval_t e2_q [3];
  dval_t d2_q [3];
  dmag_t dm2_q [3];
  dmag_t dmag_d [3];
  logic  face_ok_d;
  logic  face_ok_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= (TW'(lo_i[i]) + TW'(hi_i[i])) - (TW'(p1_i[i]) + TW'(p2_i[i]));
        e_q[i] <= EW'(hi_i[i]) - EW'(lo_i[i]);
        d_q[i] <= DW'(p2_i[i]) - DW'(p1_i[i]);
      end
    end
  end

  always_comb begin
    fval_t tmag;
    fval_t bound;
    face_ok_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dmag_d[i] = d_q[i][DW-1] ? dmag_t'(-d_q[i]) : dmag_t'(d_q[i]);
      tmag      = t_q[i][TW-1] ? -FW'(t_q[i]) : FW'(t_q[i]);
      bound     = FW'(e_q[i]) + FW'({1'b0, dmag_d[i]});
      if (tmag > bound) face_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      t2_q      <= t_q;
      e2_q      <= e_q;
      d2_q      <= d_q;
      dm2_q     <= dmag_d;
      face_ok_q <= face_ok_d;
    end
  end

  assign t_o       = t2_q;
  assign e_o       = e2_q;
  assign d_o       = d2_q;
  assign dmag_o    = dm2_q;
  assign face_ok_o = face_ok_q;

endmodule

// ===== rtl/sao_cross.sv =====
// stages 3 and 4 of one cross-product axis test, separation flag out
// depends on sao_pkg
module sao_cross (
  input  logic             clk_i,
  input  sao_pkg::sao_en_t en_i,
  input  sao_pkg::tval_t   tj_i,
  input  sao_pkg::tval_t   tk_i,
  input  sao_pkg::dval_t   dj_i,
  input  sao_pkg::dval_t   dk_i,
  input  sao_pkg::eval_t   ej_i,
  input  sao_pkg::eval_t   ek_i,
  input  sao_pkg::dmag_t   dmj_i,
  input  sao_pkg::dmag_t   dmk_i,
  output logic             sep_o
);
  import sao_pkg::*;

  prod_t m1_q, m2_q, n1_q, n2_q;
  sum_t  a_q, r_q;
  cmp_t  amag;

  // four products
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      m1_q <= prod_t'(tj_i) * prod_t'(dk_i);
      m2_q <= prod_t'(tk_i) * prod_t'(dj_i);
      n1_q <= prod_t'(ej_i) * prod_t'({1'b0, dmk_i});
      n2_q <= prod_t'(ek_i) * prod_t'({1'b0, dmj_i});
    end
  end

  // projected offset and projected radius
  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      a_q <= sum_t'(m1_q) - sum_t'(m2_q);
      r_q <= sum_t'(n1_q) + sum_t'(n2_q);
    end
  end

  assign amag  = a_q[SW-1] ? -cmp_t'(a_q) : cmp_t'(a_q);
  assign sep_o = amag > cmp_t'(r_q);

endmodule

// ===== rtl/segment_aabb_overlap_test.sv =====
// top level of the segment versus axis-aligned box overlap block
// depends on sao_pkg, sao_prep and sao_cross
//
// usage:
//   one request carries a segment (seg_start_*, seg_end_*) and a box
//   (box_lo_*, box_hi_*), all signed q16.8. it is taken on an edge where
//   in_valid_i and in_ready_o are both high.
//   one result per request comes back on overlaps_o with out_valid_o,
//   taken on an edge where out_valid_o and out_ready_i are both high.
//   overlaps_o is 1 when the segment touches or crosses the box.
// pipeline: five register stages, stage 5 being the output register.
// throughput: one request per cycle while out_ready_i stays high; every
//   stage loads whenever it is empty or the stage after it moves on.
// reset: rst_ni clears all stage valid bits; the pipe comes up empty
//   with in_ready_o high.
// stall: while out_ready_i is low the result holds; upstream stages keep
//   filling their empty slots and in_ready_o drops only once every
//   stage holds a request.
module segment_aabb_overlap_test (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sao_pkg::coord_t seg_start_x_i,
  input  sao_pkg::coord_t seg_start_y_i,
  input  sao_pkg::coord_t seg_start_z_i,
  input  sao_pkg::coord_t seg_end_x_i,
  input  sao_pkg::coord_t seg_end_y_i,
  input  sao_pkg::coord_t seg_end_z_i,
  input  sao_pkg::coord_t box_lo_x_i,
  input  sao_pkg::coord_t box_lo_y_i,
  input  sao_pkg::coord_t box_lo_z_i,
  input  sao_pkg::coord_t box_hi_x_i,
  input  sao_pkg::coord_t box_hi_y_i,
  input  sao_pkg::coord_t box_hi_z_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            overlaps_o
);
  import sao_pkg::*;

  localparam int NSTAGE = 5;

  // per-stage valid bits; index 0 is stage 1, the last is the output
  logic [NSTAGE-1:0] valid_q, valid_d;
  logic [NSTAGE-1:0] rdy;
  sao_en_t           en;

  coord_t p1 [3];
  coord_t p2 [3];
  coord_t lo [3];
  coord_t hi [3];
  tval_t  t  [3];
  eval_t  e  [3];
  dval_t  d  [3];
  dmag_t  dm [3];
  logic   face_ok;
  logic   face3_q, face4_q;
  logic [2:0] sep;
  logic   hit_q, hit_d;

  assign p1 = '{seg_start_x_i, seg_start_y_i, seg_start_z_i};
  assign p2 = '{seg_end_x_i, seg_end_y_i, seg_end_z_i};
  assign lo = '{box_lo_x_i, box_lo_y_i, box_lo_z_i};
  assign hi = '{box_hi_x_i, box_hi_y_i, box_hi_z_i};

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    rdy[NSTAGE-1] = !valid_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stages 1-2: offsets, extents, direction, face axes
  sao_prep u_prep (
    .clk_i     (clk_i),
    .en_i      (en),
    .p1_i      (p1),
    .p2_i      (p2),
    .lo_i      (lo),
    .hi_i      (hi),
    .t_o       (t),
    .e_o       (e),
    .d_o       (d),
    .dmag_o    (dm),
    .face_ok_o (face_ok)
  );

  // stages 3-4: the three cross axes, d x (1,0,0), d x (0,1,0), d x (0,0,1)
  sao_cross u_cross_x (
    .clk_i (clk_i), .en_i (en),
    .tj_i (t[1]), .tk_i (t[2]), .dj_i (d[1]), .dk_i (d[2]),
    .ej_i (e[1]), .ek_i (e[2]), .dmj_i (dm[1]), .dmk_i (dm[2]),
    .sep_o (sep[0])
  );

  sao_cross u_cross_y (
    .clk_i (clk_i), .en_i (en),
    .tj_i (t[2]), .tk_i (t[0]), .dj_i (d[2]), .dk_i (d[0]),
    .ej_i (e[2]), .ek_i (e[0]), .dmj_i (dm[2]), .dmk_i (dm[0]),
    .sep_o (sep[1])
  );

  sao_cross u_cross_z (
    .clk_i (clk_i), .en_i (en),
    .tj_i (t[0]), .tk_i (t[1]), .dj_i (d[0]), .dk_i (d[1]),
    .ej_i (e[0]), .ek_i (e[1]), .dmj_i (dm[0]), .dmk_i (dm[1]),
    .sep_o (sep[2])
  );

  // face result rides along beside the cross products
  always_ff @(posedge clk_i) begin
    if (en.s3) face3_q <= face_ok;
    if (en.s4) face4_q <= face3_q;
  end

  // stage 5: final compare and output register
  assign hit_d = face4_q && (sep == 3'b000);

  always_ff @(posedge clk_i) begin
    if (rdy[NSTAGE-1]) hit_q <= hit_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NSTAGE-1];
  assign overlaps_o  = hit_q;

endmodule

// ===== rtl/sao_checker.sv =====
// port-level checker for the overlap block, bound to the top level
// depends on segment_aabb_overlap_test_macros.svh
`include "segment_aabb_overlap_test_macros.svh"

module sao_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic overlaps_i
);

  // stalled result holds
  `SAO_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(overlaps_i))

  // nothing comes out of a pipe in reset
  `SAO_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_i)

  // a free sink never backs up the source
  `SAO_ASSERT_ALWAYS(a_ready_flow, out_ready_i |-> in_ready_i)

  // backpressure only when the output is full and stalled
  `SAO_ASSERT_ALWAYS(a_full_stall, !in_ready_i |-> out_valid_i && !out_ready_i)

endmodule

bind segment_aabb_overlap_test sao_checker u_sao_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .overlaps_i  (overlaps_o)
);
